@@ hdl/credit_priority_thread_scheduler_core_macros.svh @@
// Assertion macros used by the scheduler's checker file.
`ifndef CREDIT_PRIORITY_THREAD_SCHEDULER_CORE_MACROS_SVH
`define CREDIT_PRIORITY_THREAD_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define CPTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, switched off while reset is asserted.
`define CPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

@@ hdl/cpts_pkg.sv @@
// Shared types and constants of the credit priority thread scheduler.
package cpts_pkg;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_BLOCK  = 3'd2,
		CMD_WAKE   = 3'd3,
		CMD_FINISH = 3'd4,
		CMD_CANCEL = 3'd5,
		CMD_REMOVE = 3'd6,
		CMD_NOP    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_FREE   = 3'd0,
		ST_NEW    = 3'd1,
		ST_RUN    = 3'd2,
		ST_BLOCK  = 3'd3,
		ST_DONE   = 3'd4,
		ST_CANCEL = 3'd5
	} slot_state_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_NO_RUN = 3'd1,
		STAT_BUSY   = 3'd2,
		STAT_FREE   = 3'd3,
		STAT_WRONG  = 3'd4
	} stat_t;

	// A command after classification by the front end.
	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] slot;
		logic [7:0] prio;
		logic       in_range;
	} req_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int RAM_WIDTH   = 16;

endpackage

@@ hdl/cpts_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module cpts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/cpts_front.sv @@
// Front end: accepts command beats, classifies them and queues them.
module cpts_front #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2:0]          s_tuser,
	input  logic [15:0]         s_tdata,
	output logic                q_valid,
	output cpts_pkg::req_t      q_head,
	input  logic                q_pop
);

	localparam int QAW = $clog2(cpts_pkg::QUEUE_DEPTH);
	localparam int QCW = $clog2(cpts_pkg::QUEUE_DEPTH + 1);

	cpts_pkg::req_t entry_q [cpts_pkg::QUEUE_DEPTH];
	cpts_pkg::req_t req;
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;

	// Bits 15 to 12 of the beat are padding.
	always_comb begin
		req.cmd      = cpts_pkg::cmd_t'(s_tuser);
		req.slot     = s_tdata[3:0];
		req.prio     = s_tdata[11:4];
		req.in_range = 32'(s_tdata[3:0]) < SLOTS;
	end

	assign s_tready = count_q != QCW'(cpts_pkg::QUEUE_DEPTH);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != '0;
	assign q_head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

@@ hdl/cpts_engine.sv @@
// Back end: slot table, tick scan sequencer and result register.
module cpts_engine #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic                q_valid,
	input  cpts_pkg::req_t      q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PASS1 = 5'b00010,
		S_PASS2 = 5'b00100,
		S_WRBK  = 5'b01000,
		S_RESP  = 5'b10000
	} fsm_t;

	fsm_t                   state_q;
	cpts_pkg::slot_state_t  status_q [SLOTS];
	logic [IW-1:0]          cur_q;
	logic [7:0]             cur_credit_q;
	logic [7:0]             main_prio_q;
	logic                   init_pend_q;

	logic [IW-1:0]          ptr_q;
	logic [CW-1:0]          cnt_q;
	logic                   rd_vld_s1, rd_run_s1;
	logic [IW-1:0]          rd_idx_s1;
	logic [7:0]             maxc_q, best_prio_q;
	logic [IW-1:0]          best_q;
	logic                   found_q, any_q;

	cpts_pkg::stat_t        res_status_q;
	logic                   res_sw_q;
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;

	logic                   ram_we, ram_re;
	logic [IW-1:0]          ram_waddr;
	logic [cpts_pkg::RAM_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [7:0]             rd_credit, rd_prio, new_credit;

	logic [IW-1:0]          h_idx;
	cpts_pkg::slot_state_t  h_state;
	cpts_pkg::slot_state_t  ex_next;
	cpts_pkg::stat_t        ex_status;
	logic                   ex_wr_st, ex_ram_we;
	logic                   issue, issue_run, cnt_done, pass_end, out_load;

	cpts_ram #(
		.WIDTH (cpts_pkg::RAM_WIDTH),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign rd_credit  = ram_rdata[7:0];
	assign rd_prio    = ram_rdata[15:8];
	assign new_credit = (maxc_q != 8'd0) ? maxc_q - 8'd1 : 8'd0;

	assign cnt_done  = cnt_q == CW'(SLOTS);
	assign issue     = ((state_q == S_PASS1) || (state_q == S_PASS2)) && !cnt_done;
	assign issue_run = (status_q[ptr_q] == cpts_pkg::ST_RUN) ||
		(status_q[ptr_q] == cpts_pkg::ST_NEW);
	assign pass_end  = cnt_done && !rd_vld_s1;
	assign ram_re    = issue;

	assign q_pop    = (state_q == S_IDLE) && !init_pend_q && q_valid;
	assign out_load = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Decode of every command except tick, done in the cycle it leaves the queue.
	always_comb begin
		h_idx     = IW'(q_head.slot);
		h_state   = q_head.in_range ? status_q[h_idx] : cpts_pkg::ST_FREE;
		ex_next   = cpts_pkg::ST_FREE;
		ex_status = cpts_pkg::STAT_OK;
		ex_wr_st  = 1'b0;
		ex_ram_we = 1'b0;
		case (q_head.cmd)
			cpts_pkg::CMD_CREATE: begin
				if (q_head.in_range && h_state == cpts_pkg::ST_FREE) begin
					ex_next   = cpts_pkg::ST_NEW;
					ex_wr_st  = 1'b1;
					ex_ram_we = 1'b1;
				end else begin
					ex_status = cpts_pkg::STAT_BUSY;
				end
			end
			cpts_pkg::CMD_BLOCK, cpts_pkg::CMD_WAKE, cpts_pkg::CMD_FINISH,
			cpts_pkg::CMD_CANCEL, cpts_pkg::CMD_REMOVE: begin
				ex_status = cpts_pkg::STAT_WRONG;
				if (!q_head.in_range || h_state == cpts_pkg::ST_FREE) begin
					ex_status = cpts_pkg::STAT_FREE;
				end else begin
					case (q_head.cmd)
						cpts_pkg::CMD_BLOCK: begin
							if (h_state == cpts_pkg::ST_RUN) begin
								ex_next  = cpts_pkg::ST_BLOCK;
								ex_wr_st = 1'b1;
							end
						end
						cpts_pkg::CMD_WAKE: begin
							if (h_state == cpts_pkg::ST_BLOCK) begin
								ex_next  = cpts_pkg::ST_RUN;
								ex_wr_st = 1'b1;
							end
						end
						cpts_pkg::CMD_FINISH: begin
							if (h_state == cpts_pkg::ST_RUN || h_state == cpts_pkg::ST_NEW) begin
								ex_next  = cpts_pkg::ST_DONE;
								ex_wr_st = 1'b1;
							end
						end
						cpts_pkg::CMD_CANCEL: begin
							if (h_idx != cur_q && (h_state == cpts_pkg::ST_RUN ||
								h_state == cpts_pkg::ST_BLOCK ||
								h_state == cpts_pkg::ST_NEW)) begin
								ex_next  = cpts_pkg::ST_CANCEL;
								ex_wr_st = 1'b1;
							end
						end
						default: begin
							if (h_idx != cur_q && (h_state == cpts_pkg::ST_DONE ||
								h_state == cpts_pkg::ST_CANCEL)) begin
								ex_next  = cpts_pkg::ST_FREE;
								ex_wr_st = 1'b1;
							end
						end
					endcase
					if (ex_wr_st) begin
						ex_status = cpts_pkg::STAT_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Single write port of the priority and credit store.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = {rd_prio, rd_prio};
		case (state_q)
			S_IDLE: begin
				if (init_pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = {main_prio_q, main_prio_q};
				end else if (q_pop && ex_ram_we) begin
					ram_we    = 1'b1;
					ram_waddr = h_idx;
					ram_wdata = {q_head.prio, q_head.prio};
				end
			end
			S_PASS2: begin
				ram_we = rd_vld_s1 && rd_run_s1;
			end
			S_WRBK: begin
				ram_we    = 1'b1;
				ram_waddr = best_q;
				ram_wdata = {best_prio_q, new_credit};
			end
			default: begin
			end
		endcase
	end

	// Slot states, current slot and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= (i == 0) ? cpts_pkg::ST_RUN : cpts_pkg::ST_FREE;
			end
			cur_q        <= '0;
			cur_credit_q <= 8'd1;
			main_prio_q  <= 8'd1;
			init_pend_q  <= 1'b1;
		end else if (cfg_wr_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= (i == 0) ? cpts_pkg::ST_RUN : cpts_pkg::ST_FREE;
			end
			cur_q        <= '0;
			cur_credit_q <= cfg_wr_data;
			main_prio_q  <= cfg_wr_data;
			init_pend_q  <= 1'b1;
		end else begin
			if (state_q == S_IDLE) begin
				init_pend_q <= 1'b0;
			end
			if (q_pop && ex_wr_st) begin
				status_q[h_idx] <= ex_next;
			end
			if (issue && state_q == S_PASS1 && status_q[ptr_q] == cpts_pkg::ST_NEW) begin
				status_q[ptr_q] <= cpts_pkg::ST_RUN;
			end
			if (state_q == S_WRBK) begin
				cur_q        <= best_q;
				cur_credit_q <= new_credit;
			end
		end
	end

	// Scan sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			any_q        <= 1'b0;
			res_sw_q     <= 1'b0;
			res_status_q <= cpts_pkg::STAT_OK;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_run_s1 <= issue_run;
				rd_idx_s1 <= ptr_q;
				ptr_q     <= (ptr_q == IW'(SLOTS - 1)) ? '0 : ptr_q + IW'(1);
				cnt_q     <= cnt_q + CW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {cur_credit_q, res_status_q, res_sw_q, 4'(cur_q)};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						res_sw_q     <= 1'b0;
						res_status_q <= ex_status;
						if (q_head.cmd == cpts_pkg::CMD_TICK) begin
							ptr_q   <= cur_q;
							cnt_q   <= '0;
							maxc_q  <= 8'd0;
							found_q <= 1'b0;
							any_q   <= 1'b0;
							state_q <= S_PASS1;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_PASS1: begin
					if (rd_vld_s1 && rd_run_s1) begin
						any_q <= 1'b1;
						if (rd_credit > maxc_q) begin
							maxc_q      <= rd_credit;
							best_q      <= rd_idx_s1;
							best_prio_q <= rd_prio;
							found_q     <= 1'b1;
						end
					end
					if (pass_end) begin
						if (!any_q) begin
							res_status_q <= cpts_pkg::STAT_NO_RUN;
							state_q      <= S_RESP;
						end else if (found_q) begin
							state_q <= S_WRBK;
						end else begin
							ptr_q   <= cur_q;
							cnt_q   <= '0;
							state_q <= S_PASS2;
						end
					end
				end
				S_PASS2: begin
					if (rd_vld_s1 && rd_run_s1 && (!found_q || rd_prio > maxc_q)) begin
						maxc_q      <= rd_prio;
						best_q      <= rd_idx_s1;
						best_prio_q <= rd_prio;
						found_q     <= 1'b1;
					end
					if (pass_end) begin
						state_q <= S_WRBK;
					end
				end
				S_WRBK: begin
					res_sw_q     <= best_q != cur_q;
					res_status_q <= cpts_pkg::STAT_OK;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/credit_priority_thread_scheduler_core.sv @@
// Top level of the credit priority thread scheduler.
//
// Commands arrive on the s_ channel (code on s_tuser, slot and priority on
// s_tdata) and each gives exactly one result beat on the m_ channel, in order.
// A tick picks the runnable slot with the highest credit, scanning the ring
// from the current slot; the other commands create, block, wake, finish,
// cancel or remove a slot. A small queue between the front end and the
// engine lets a beat be taken while the engine is busy or a result waits.
// The engine takes one command at a time from the queue. A tick reads the
// priority and credit store once per slot in each pass over a single RAM
// read port: one pass when a running slot still has credit, two when every
// credit has to be reloaded first.
// Reset leaves slot zero running with priority and credit one; a write on the
// configuration port sets slot zero's priority and re-initialises the whole
// table, and the engine stores slot zero's entry while idle before it takes
// the next command. When the receiver stalls, the result beat holds in the
// output register, the engine waits, and the queue fills and then drops
// s_tready.
module credit_priority_thread_scheduler_core #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,  // main_priority
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,      // command[2:0]
	input  logic [15:0] s_tdata,      // slot[3:0], priority_req[11:4], pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata       // selected_slot[3:0], switched[4], status[7:5],
	                                  // credit_left[15:8]
);

	logic           q_valid;
	logic           q_pop;
	cpts_pkg::req_t q_head;

	// The front end classifies and queues commands; all table state lives in the engine.
	cpts_front #(
		.SLOTS (SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// The engine holds slot states in flip-flops and priority with credit
	// in a RAM, and owns the output register.
	cpts_engine #(
		.SLOTS (SLOTS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

@@ hdl/cpts_checker.sv @@
// Port-level checks of the scheduler and their attachment to the top level.
`include "credit_priority_thread_scheduler_core_macros.svh"

module cpts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result beat keeps its contents.
	`CPTS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Only the five defined status codes are ever reported.
	`CPTS_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tdata[7:5] <= 3'd4)

	// A thread switch is only reported together with the OK status.
	`CPTS_ASSERT_NOW(a_switch_ok, clk, arst_n, m_tvalid && m_tdata[4], m_tdata[7:5] == 3'd0)

endmodule

bind credit_priority_thread_scheduler_core cpts_checker u_cpts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
